// File: rtl/assert_macros.svh
// assertion macros for the triangle stiffness block
// expects clk and rst_n in the scope of use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every edge out of reset
`define LTS_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// condition in one cycle implies a consequence in the next
`define LTS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/lts_pkg.sv
// widths, constants and types of the triangle stiffness pipeline
// no dependencies
`default_nettype none

package lts_pkg;

  localparam int COORD_W     = 16;
  localparam int DIFF_W      = COORD_W + 1;
  localparam int PROD_W      = 2 * DIFF_W;
  localparam int SUM_W       = PROD_W + 1;
  localparam int MAG_W       = 33;
  localparam int AD_W        = 33;
  localparam int COND_W      = 16;
  localparam int CM_W        = COND_W + MAG_W;
  localparam int ROUND_SHIFT = 8;
  localparam int NUM_W       = CM_W + ROUND_SHIFT + 1;
  localparam int DEN_W       = AD_W + 1;
  localparam int QUO_W       = 31;
  localparam int NUM_HI_W    = NUM_W - QUO_W;
  localparam int DIV_STEPS   = QUO_W;
  localparam int ENTRY_W     = 32;
  localparam int ABS_DET_W   = 35;
  localparam int NUM_VERT    = 3;
  localparam int NUM_ENTRIES = 6;

  localparam logic [COND_W-1:0]  COND_RESET = COND_W'(256);
  localparam logic [ENTRY_W-1:0] ENTRY_MAX  = {1'b0, {(ENTRY_W-1){1'b1}}};
  localparam logic [ENTRY_W-1:0] ENTRY_MIN  = {1'b1, {(ENTRY_W-1){1'b0}}};

  // row and column of each distinct entry, upper triangle in row order
  localparam logic [1:0] ENTRY_ROW [NUM_ENTRIES] = '{2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd2};
  localparam logic [1:0] ENTRY_COL [NUM_ENTRIES] = '{2'd0, 2'd1, 2'd2, 2'd1, 2'd2, 2'd2};

  typedef logic signed [DIFF_W-1:0] diff_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [SUM_W-1:0]  sum_t;

  // one entry's state inside the divider
  typedef struct packed {
    logic [DEN_W-1:0] rem;
    logic [QUO_W-1:0] bits;
    logic             neg;
    logic             sat;
  } div_lane_t;

  // per-triangle data travelling beside the divider lanes
  typedef struct packed {
    logic [AD_W-1:0] ad;
    logic            deg;
  } div_ctl_t;

endpackage

`default_nettype wire

// File: rtl/linear_triangle_stiffness_matrix.sv
// linear triangle element stiffness: six matrix entries and |det| per triangle
// depends on lts_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

// channel  | direction | handshake              | payload
// in_      | input     | in_valid / in_stall    | three vertices, signed Q8.8
// out_     | output    | out_valid / out_stall  | six Q16.16 entries, abs_det, degenerate
// cfg_     | input     | cfg_valid / cfg_ready  | conductivity, unsigned Q8.8
//
// one triangle per cycle while the output is not stalled; six arithmetic stages, a range-check
// stage, a 31-stage restoring divider (one quotient bit per stage) and the output register
// rst_n clears the valid bits and sets conductivity to 1.0
// a stalled output freezes the whole pipeline, in_stall follows at once

module linear_triangle_stiffness_matrix import lts_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic signed [COORD_W-1:0] in_first_x,
  input  logic signed [COORD_W-1:0] in_first_y,
  input  logic signed [COORD_W-1:0] in_second_x,
  input  logic signed [COORD_W-1:0] in_second_y,
  input  logic signed [COORD_W-1:0] in_third_x,
  input  logic signed [COORD_W-1:0] in_third_y,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [ENTRY_W-1:0] out_entry_00,
  output logic signed [ENTRY_W-1:0] out_entry_01,
  output logic signed [ENTRY_W-1:0] out_entry_02,
  output logic signed [ENTRY_W-1:0] out_entry_11,
  output logic signed [ENTRY_W-1:0] out_entry_12,
  output logic signed [ENTRY_W-1:0] out_entry_22,
  output logic [ABS_DET_W-1:0]      out_abs_det,
  output logic                      out_degenerate,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [COND_W-1:0]         cfg_conductivity
);

  function automatic div_lane_t div_step(input div_lane_t lane, input logic [DEN_W-1:0] den);
    logic [DEN_W:0] trial;
    logic           qb;
    div_lane_t      res;
    trial = {lane.rem, lane.bits[QUO_W-1]};
    qb    = (trial >= {1'b0, den});
    if (qb) begin
      trial = trial - {1'b0, den};
    end
    res      = lane;
    res.rem  = trial[DEN_W-1:0];
    res.bits = {lane.bits[QUO_W-2:0], qb};
    return res;
  endfunction

  logic adv;

  logic [COND_W-1:0] cond_r;

  logic                 s1_vld_r, s2_vld_r, s3_vld_r, s4_vld_r, s5_vld_r, s6_vld_r;
  logic [DIV_STEPS:0]   dv_vld_r;
  logic                 out_valid_r;

  diff_t dy_nxt [NUM_VERT];
  diff_t dx_nxt [NUM_VERT];
  diff_t dy_r   [NUM_VERT];
  diff_t dx_r   [NUM_VERT];

  prod_t pyy_r [NUM_ENTRIES];
  prod_t pxx_r [NUM_ENTRIES];
  prod_t pa_r, pb_r;

  sum_t s_r [NUM_ENTRIES];
  sum_t det_r;

  logic [MAG_W-1:0] mag_nxt [NUM_ENTRIES];
  logic [MAG_W-1:0] mag_r   [NUM_ENTRIES];
  logic [NUM_ENTRIES-1:0] neg4_r, neg5_r, neg6_r;
  logic [AD_W-1:0]  ad_nxt, ad4_r, ad5_r, ad6_r;
  logic             deg4_r, deg5_r, deg6_r;

  logic [CM_W-1:0]  cm_r  [NUM_ENTRIES];
  logic [NUM_W-1:0] num_r [NUM_ENTRIES];

  logic [DEN_W-1:0] den6;
  div_lane_t dv_lane_nxt [DIV_STEPS+1][NUM_ENTRIES];
  div_lane_t dv_lane_r   [DIV_STEPS+1][NUM_ENTRIES];
  div_ctl_t  dv_ctl_nxt  [DIV_STEPS+1];
  div_ctl_t  dv_ctl_r    [DIV_STEPS+1];

  logic [ENTRY_W-1:0]   entry_nxt [NUM_ENTRIES];
  logic [ENTRY_W-1:0]   entry_r   [NUM_ENTRIES];
  logic [ABS_DET_W-1:0] abs_det_r;
  logic                 degenerate_r;

  assign adv       = !out_valid_r || !out_stall;
  assign in_stall  = !adv;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cond_r <= COND_RESET;
    end else if (cfg_valid && cfg_ready) begin
      cond_r <= cfg_conductivity;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r    <= 1'b0;
      s2_vld_r    <= 1'b0;
      s3_vld_r    <= 1'b0;
      s4_vld_r    <= 1'b0;
      s5_vld_r    <= 1'b0;
      s6_vld_r    <= 1'b0;
      dv_vld_r    <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r    <= in_valid;
      s2_vld_r    <= s1_vld_r;
      s3_vld_r    <= s2_vld_r;
      s4_vld_r    <= s3_vld_r;
      s5_vld_r    <= s4_vld_r;
      s6_vld_r    <= s5_vld_r;
      dv_vld_r    <= {dv_vld_r[DIV_STEPS-1:0], s6_vld_r};
      out_valid_r <= dv_vld_r[DIV_STEPS];
    end
  end

  // gradient coefficients
  always_comb begin
    dy_nxt[0] = DIFF_W'(in_second_y) - DIFF_W'(in_third_y);
    dy_nxt[1] = DIFF_W'(in_third_y)  - DIFF_W'(in_first_y);
    dy_nxt[2] = DIFF_W'(in_first_y)  - DIFF_W'(in_second_y);
    dx_nxt[0] = DIFF_W'(in_third_x)  - DIFF_W'(in_second_x);
    dx_nxt[1] = DIFF_W'(in_first_x)  - DIFF_W'(in_third_x);
    dx_nxt[2] = DIFF_W'(in_second_x) - DIFF_W'(in_first_x);
  end

  // magnitudes of the coefficient sums and of det
  always_comb begin
    for (int e = 0; e < NUM_ENTRIES; e++) begin
      mag_nxt[e] = s_r[e][SUM_W-1] ? MAG_W'(-s_r[e]) : MAG_W'(s_r[e]);
    end
    ad_nxt = det_r[SUM_W-1] ? AD_W'(-det_r) : AD_W'(det_r);
  end

  // divider: first stage checks the quotient range, then one bit per stage
  assign den6 = {ad6_r, 1'b0};

  always_comb begin
    for (int e = 0; e < NUM_ENTRIES; e++) begin
      dv_lane_nxt[0][e].rem  = DEN_W'(num_r[e][NUM_W-1:QUO_W]);
      dv_lane_nxt[0][e].bits = num_r[e][QUO_W-1:0];
      dv_lane_nxt[0][e].neg  = neg6_r[e];
      dv_lane_nxt[0][e].sat  = (DEN_W'(num_r[e][NUM_W-1:QUO_W]) >= den6);
    end
    dv_ctl_nxt[0].ad  = ad6_r;
    dv_ctl_nxt[0].deg = deg6_r;
    for (int k = 1; k <= DIV_STEPS; k++) begin
      for (int e = 0; e < NUM_ENTRIES; e++) begin
        dv_lane_nxt[k][e] = div_step(dv_lane_r[k-1][e], {dv_ctl_r[k-1].ad, 1'b0});
      end
      dv_ctl_nxt[k] = dv_ctl_r[k-1];
    end
  end

  // sign, saturation and the degenerate case
  always_comb begin
    for (int e = 0; e < NUM_ENTRIES; e++) begin
      if (dv_ctl_r[DIV_STEPS].deg) begin
        entry_nxt[e] = '0;
      end else if (dv_lane_r[DIV_STEPS][e].sat) begin
        entry_nxt[e] = dv_lane_r[DIV_STEPS][e].neg ? ENTRY_MIN : ENTRY_MAX;
      end else if (dv_lane_r[DIV_STEPS][e].neg) begin
        entry_nxt[e] = -{1'b0, dv_lane_r[DIV_STEPS][e].bits};
      end else begin
        entry_nxt[e] = {1'b0, dv_lane_r[DIV_STEPS][e].bits};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dy_r <= dy_nxt;
      dx_r <= dx_nxt;
      for (int e = 0; e < NUM_ENTRIES; e++) begin
        pyy_r[e]  <= dy_r[ENTRY_ROW[e]] * dy_r[ENTRY_COL[e]];
        pxx_r[e]  <= dx_r[ENTRY_ROW[e]] * dx_r[ENTRY_COL[e]];
        s_r[e]    <= SUM_W'(pyy_r[e]) + SUM_W'(pxx_r[e]);
        mag_r[e]  <= mag_nxt[e];
        neg4_r[e] <= s_r[e][SUM_W-1];
        cm_r[e]   <= CM_W'(cond_r) * CM_W'(mag_r[e]);
        num_r[e]  <= NUM_W'({cm_r[e], {ROUND_SHIFT{1'b0}}}) + NUM_W'(ad5_r);
      end
      pa_r      <= dx_r[2] * dy_r[1];
      pb_r      <= dx_r[1] * dy_r[2];
      det_r     <= SUM_W'(pa_r) - SUM_W'(pb_r);
      ad4_r     <= ad_nxt;
      deg4_r    <= (det_r == '0);
      neg5_r    <= neg4_r;
      ad5_r     <= ad4_r;
      deg5_r    <= deg4_r;
      neg6_r    <= neg5_r;
      ad6_r     <= ad5_r;
      deg6_r    <= deg5_r;
      dv_lane_r <= dv_lane_nxt;
      dv_ctl_r  <= dv_ctl_nxt;
      entry_r   <= entry_nxt;
      abs_det_r    <= ABS_DET_W'(dv_ctl_r[DIV_STEPS].ad);
      degenerate_r <= dv_ctl_r[DIV_STEPS].deg;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_entry_00   = entry_r[0];
  assign out_entry_01   = entry_r[1];
  assign out_entry_02   = entry_r[2];
  assign out_entry_11   = entry_r[3];
  assign out_entry_12   = entry_r[4];
  assign out_entry_22   = entry_r[5];
  assign out_abs_det    = abs_det_r;
  assign out_degenerate = degenerate_r;

  // zero determinant and degenerate flag agree, diagonal entries cleared
  `LTS_ASSERT(a_degen_zero,
              !out_valid_r || ((abs_det_r == '0) == degenerate_r),
              "abs_det and degenerate disagree")
  `LTS_ASSERT(a_degen_entries,
              !(out_valid_r && degenerate_r) ||
              ((entry_r[0] == '0) && (entry_r[3] == '0) && (entry_r[5] == '0)),
              "degenerate triangle with nonzero diagonal")
  // diagonal entries come from sums of squares
  `LTS_ASSERT(a_diag_sign,
              !out_valid_r ||
              (!entry_r[0][ENTRY_W-1] && !entry_r[3][ENTRY_W-1] && !entry_r[5][ENTRY_W-1]),
              "negative diagonal entry")
  // a held result freezes the pipeline
  `LTS_ASSERT_NEXT(a_pipe_hold, out_valid_r && out_stall,
                   $stable(dv_vld_r) && $stable(s6_vld_r) && out_valid_r,
                   "pipeline moved under stall")

endmodule

`default_nettype wire

// File: bench/tb.sv
`timescale 1ns / 1ps
// testbench for linear_triangle_stiffness_matrix: directed table, then random triangles
// over several conductivity settings, each transfer checked against a typed result or an in-bench predictor
// depends on lts_pkg and the rtl top level

module tb;
  import lts_pkg::*;

  localparam int NUM_DIRECTED = 14;
  localparam int NUM_PHASES   = 7;
  localparam int PHASE_ITEMS  = 257;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 60;

  typedef struct packed {
    logic signed [COORD_W-1:0] first_x;
    logic signed [COORD_W-1:0] first_y;
    logic signed [COORD_W-1:0] second_x;
    logic signed [COORD_W-1:0] second_y;
    logic signed [COORD_W-1:0] third_x;
    logic signed [COORD_W-1:0] third_y;
  } triangle_t;

  typedef struct packed {
    logic [NUM_ENTRIES-1:0][ENTRY_W-1:0] entry;
    logic [ABS_DET_W-1:0]                abs_det;
    logic                                degenerate;
  } stiffness_t;

  typedef struct packed {
    triangle_t  shape;
    logic       known;
    stiffness_t want;
  } directed_row_t;

  localparam stiffness_t FLAT_RESULT = '{'0, '0, 1'b1};
  localparam stiffness_t UNIT_RESULT = '{
    {32'h0000_8000, 32'h0000_0000, 32'h0000_8000,
     32'hFFFF_8000, 32'hFFFF_8000, 32'h0001_0000},
    35'd65536, 1'b0};
  localparam stiffness_t NOT_TYPED = '0;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                      in_valid;
  logic                      in_stall;
  logic signed [COORD_W-1:0] in_first_x;
  logic signed [COORD_W-1:0] in_first_y;
  logic signed [COORD_W-1:0] in_second_x;
  logic signed [COORD_W-1:0] in_second_y;
  logic signed [COORD_W-1:0] in_third_x;
  logic signed [COORD_W-1:0] in_third_y;
  logic                      out_valid;
  logic                      out_stall;
  logic signed [ENTRY_W-1:0] out_entry_00;
  logic signed [ENTRY_W-1:0] out_entry_01;
  logic signed [ENTRY_W-1:0] out_entry_02;
  logic signed [ENTRY_W-1:0] out_entry_11;
  logic signed [ENTRY_W-1:0] out_entry_12;
  logic signed [ENTRY_W-1:0] out_entry_22;
  logic [ABS_DET_W-1:0]      out_abs_det;
  logic                      out_degenerate;
  logic                      cfg_valid;
  logic                      cfg_ready;
  logic [COND_W-1:0]         cfg_conductivity;

  logic [COND_W-1:0] model_conductivity = COND_RESET;
  stiffness_t        pending_stiffness [$];
  bit                calm;
  bit                hold_request;
  int                mismatches;
  int                triangles_sent;
  int                results_seen;
  int                flat_seen;
  int                saturated_seen;

  directed_row_t directed_rows [NUM_DIRECTED] = '{
    '{'{0, 0, 0, 0, 0, 0}, 1'b1, FLAT_RESULT},
    '{'{0, 0, 256, 0, 0, 256}, 1'b1, UNIT_RESULT},
    '{'{0, 0, 0, 256, 256, 0}, 1'b1, UNIT_RESULT},
    '{'{100, 100, 100, 100, -50, 7}, 1'b1, FLAT_RESULT},
    '{'{0, 0, 256, 256, 512, 512}, 1'b1, FLAT_RESULT},
    '{'{-32768, -32768, 0, 0, 32767, 32767}, 1'b1, FLAT_RESULT},
    '{'{32767, 32767, 32767, 32767, 32767, 32767}, 1'b1, FLAT_RESULT},
    '{'{-32768, -32768, 32767, -32768, -32768, 32767}, 1'b0, NOT_TYPED},
    '{'{-32768, -32768, 32767, 32767, 32767, 32766}, 1'b0, NOT_TYPED},
    '{'{0, 0, 1, 0, 32767, 1}, 1'b0, NOT_TYPED},
    '{'{0, 0, -32768, 0, 0, -32768}, 1'b0, NOT_TYPED},
    '{'{0, 0, 1, 0, 0, 1}, 1'b0, NOT_TYPED},
    '{'{21845, -21846, -21846, 21845, 21845, 21845}, 1'b0, NOT_TYPED},
    '{'{-1, -1, 32767, -32768, -32768, 32767}, 1'b0, NOT_TYPED}
  };

  linear_triangle_stiffness_matrix dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_first_x       (in_first_x),
    .in_first_y       (in_first_y),
    .in_second_x      (in_second_x),
    .in_second_y      (in_second_y),
    .in_third_x       (in_third_x),
    .in_third_y       (in_third_y),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_entry_00     (out_entry_00),
    .out_entry_01     (out_entry_01),
    .out_entry_02     (out_entry_02),
    .out_entry_11     (out_entry_11),
    .out_entry_12     (out_entry_12),
    .out_entry_22     (out_entry_22),
    .out_abs_det      (out_abs_det),
    .out_degenerate   (out_degenerate),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_conductivity (cfg_conductivity)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic stiffness_t predict_stiffness(input triangle_t t,
                                                   input logic [COND_W-1:0] cond);
    longint            px [3];
    longint            py [3];
    longint            grad_y [3];
    longint            grad_x [3];
    longint            det;
    longint            s;
    longint unsigned   ad;
    longint unsigned   mag;
    longint unsigned   num;
    longint unsigned   q;
    stiffness_t        r;
    int                i;
    int                j;
    int                k;
    px[0] = t.first_x;
    py[0] = t.first_y;
    px[1] = t.second_x;
    py[1] = t.second_y;
    px[2] = t.third_x;
    py[2] = t.third_y;
    grad_y[0] = py[1] - py[2];
    grad_y[1] = py[2] - py[0];
    grad_y[2] = py[0] - py[1];
    grad_x[0] = px[2] - px[1];
    grad_x[1] = px[0] - px[2];
    grad_x[2] = px[1] - px[0];
    det = (px[1] - px[0]) * (py[2] - py[0]) - (px[2] - px[0]) * (py[1] - py[0]);
    ad = (det < 0) ? -det : det;
    r = '0;
    if (ad == 0) begin
      r.degenerate = 1'b1;
      return r;
    end
    k = 0;
    for (i = 0; i < NUM_VERT; i++) begin
      for (j = i; j < NUM_VERT; j++) begin
        s = grad_y[i] * grad_y[j] + grad_x[i] * grad_x[j];
        mag = (s < 0) ? -s : s;
        num = longint'(cond) * mag * 128;
        q = (2 * num + ad) / (2 * ad);
        if (s < 0) begin
          r.entry[k] = (q >= 64'h8000_0000) ? ENTRY_MIN : ENTRY_W'(-q);
        end else begin
          r.entry[k] = (q > 64'h7FFF_FFFF) ? ENTRY_MAX : ENTRY_W'(q);
        end
        k++;
      end
    end
    r.abs_det = ABS_DET_W'(ad);
    return r;
  endfunction

  function automatic logic signed [COORD_W-1:0] rand_coord(input int span);
    return COORD_W'(int'($urandom_range(0, 2 * span)) - span);
  endfunction

  function automatic triangle_t random_triangle();
    triangle_t                 t;
    int                        roll;
    logic signed [COORD_W-1:0] bx;
    logic signed [COORD_W-1:0] by;
    logic signed [COORD_W-1:0] dx;
    logic signed [COORD_W-1:0] dy;
    logic signed [COORD_W-1:0] k1;
    logic signed [COORD_W-1:0] k2;
    roll = $urandom_range(0, 99);
    if (roll < 40) begin
      bx = rand_coord(8192);
      by = rand_coord(8192);
      t = '{bx, by, bx + rand_coord(2048), by + rand_coord(2048),
            bx + rand_coord(2048), by + rand_coord(2048)};
    end else if (roll < 70) begin
      t = '{COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom),
            COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom)};
    end else if (roll < 80) begin
      // collinear or coincident vertices
      bx = rand_coord(4000);
      by = rand_coord(4000);
      dx = rand_coord(1500);
      dy = rand_coord(1500);
      k1 = rand_coord(3);
      k2 = rand_coord(3);
      t = '{bx, by, bx + k1 * dx, by + k1 * dy, bx + k2 * dx, by + k2 * dy};
    end else if (roll < 90) begin
      // thin sliver, tends to saturate
      bx = rand_coord(16000);
      by = rand_coord(16000);
      dx = rand_coord(16000);
      dy = rand_coord(16000);
      t = '{bx, by, bx + dx, by + dy, bx + dx + rand_coord(2), by + dy + rand_coord(2)};
    end else begin
      bx = rand_coord(30000);
      by = rand_coord(30000);
      t = '{bx, by, bx + rand_coord(3), by + rand_coord(3),
            bx + rand_coord(3), by + rand_coord(3)};
    end
    return t;
  endfunction

  function automatic int pick_gap();
    int roll;
    if (calm) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  task automatic report_mismatch(input string field, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatches++;
    $display("mismatch in %s at %0t: got %0h, expected %0h", field, $time, got, want);
  endtask

  task automatic send_triangle(input triangle_t shape, input logic known,
                               input stiffness_t want);
    int         gap;
    stiffness_t expected;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid    <= 1'b1;
    in_first_x  <= shape.first_x;
    in_first_y  <= shape.first_y;
    in_second_x <= shape.second_x;
    in_second_y <= shape.second_y;
    in_third_x  <= shape.third_x;
    in_third_y  <= shape.third_y;
    do @(posedge clk); while (in_stall !== 1'b0);
    expected = known ? want : predict_stiffness(shape, model_conductivity);
    pending_stiffness.insert(pending_stiffness.size(), expected);
    triangles_sent++;
  endtask

  task automatic wait_for_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_stiffness.size() != 0) @(posedge clk);
  endtask

  task automatic write_conductivity(input logic [COND_W-1:0] value);
    @(negedge clk);
    cfg_valid        <= 1'b1;
    cfg_conductivity <= value;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    model_conductivity = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // receiver side
  initial begin
    int hold;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_stall <= 1'b0;
      end else begin
        hold = pick_gap();
        out_stall <= (hold > 0);
        if (hold > 1) repeat (hold - 1) @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin : check_results
    stiffness_t got;
    stiffness_t want;
    int         k;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      got.entry = {out_entry_22, out_entry_12, out_entry_11,
                   out_entry_02, out_entry_01, out_entry_00};
      got.abs_det    = out_abs_det;
      got.degenerate = out_degenerate;
      results_seen++;
      if (got.degenerate === 1'b1) flat_seen++;
      for (k = 0; k < NUM_ENTRIES; k++)
        if (got.entry[k] === ENTRY_MAX || got.entry[k] === ENTRY_MIN) saturated_seen++;
      if (pending_stiffness.size() == 0) begin
        report_mismatch("transfer with nothing pending", got.abs_det, 0);
      end else begin
        want = pending_stiffness.pop_front();
        for (k = 0; k < NUM_ENTRIES; k++)
          if (got.entry[k] !== want.entry[k])
            report_mismatch($sformatf("entry_%0d%0d", ENTRY_ROW[k], ENTRY_COL[k]),
                            got.entry[k], want.entry[k]);
        if (got.abs_det !== want.abs_det)
          report_mismatch("abs_det", got.abs_det, want.abs_det);
        if (got.degenerate !== want.degenerate)
          report_mismatch("degenerate", got.degenerate, want.degenerate);
      end
    end
  end

  initial begin
    logic [COND_W-1:0] settings [NUM_PHASES];
    int                i;
    int                p;
    in_valid         = 1'b0;
    in_first_x       = '0;
    in_first_y       = '0;
    in_second_x      = '0;
    in_second_y      = '0;
    in_third_x       = '0;
    in_third_y       = '0;
    cfg_valid        = 1'b0;
    cfg_conductivity = '0;
    calm             = 1'b0;
    hold_request     = 1'b0;
    settings = '{16'hFFFF, 16'h0000, 16'h0001, COND_RESET, 16'h0000, 16'h0000, 16'h0000};
    for (p = 4; p < NUM_PHASES; p++) settings[p] = COND_W'($urandom);

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset conductivity is 1.0
    for (i = 0; i < NUM_DIRECTED; i++)
      send_triangle(directed_rows[i].shape, directed_rows[i].known, directed_rows[i].want);

    for (p = 0; p < NUM_PHASES; p++) begin
      wait_for_results();
      write_conductivity(settings[p]);
      calm = (p == 3);
      if (p == 1) hold_request = 1'b1;
      for (i = 0; i < PHASE_ITEMS; i++)
        send_triangle(random_triangle(), 1'b0, NOT_TYPED);
    end

    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d triangles over %0d conductivity settings, %0d results checked",
             triangles_sent, NUM_PHASES + 1, results_seen);
    $display("%0d degenerate triangles, %0d saturated entries, %0d mismatches",
             flat_seen, saturated_seen, mismatches);
    if (mismatches == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("tb: errors");
    $finish;
  end

endmodule
